// ===== hdl/sem_pkg.sv =====
// Package: constants, register indexes and types for the Sobel edge magnitude block.
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = PIX_W + 2;
    localparam int GRAD_W     = SUM_W + 1;
    localparam int MAG_W      = SUM_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic [COL_W-1:0] RST_COL_MAX = COL_W'(640 - 1);
    localparam logic [ROW_W-1:0] RST_ROW_MAX = ROW_W'(480 - 1);

    typedef logic [PIX_W-1:0] t_pix;

endpackage

// ===== hdl/sobel_edge_magnitude_3x3_top.sv =====
// Top level: streaming 3x3 Sobel edge magnitude over a raster-order grayscale frame.
//
// Input channel (i_valid / o_stall / i_pixel): one 8-bit pixel per beat, raster order.
// Output channel (o_valid / i_stall / payload): one beat per interior pixel, carrying the
// low 8 bits of |gx|+|gy|, the center column and row, and a mark on the frame's last result.
// Border pixels produce no beat.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data): index 0 is the
// image width, index 1 the image height; o_cfg_ready is always high. A write to either
// restarts the frame at column 0, row 0. Values are clamped to 3..1024 and 3..4096.
// Throughput: one pixel per cycle while o_stall is low; each result goes into the output
// register, or the skid entry while the output is held. The line stores read the next
// column ahead, so the window update, store write and kernel sum fit in the accept cycle.
// Stall: a two-entry output (register plus skid) keeps taking pixels while one result
// waits; o_stall rises only when both entries are full.
// Reset: counters return to zero, width 640, height 480, window cleared, output empty.
// Line store contents are not cleared; entries are always written before use in a frame.
module sobel_edge_magnitude_3x3_top
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_edge_value,
    output logic [COL_W-1:0]      o_center_col,
    output logic [ROW_W-1:0]      o_center_row,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef struct packed {
        t_pix             edge_value;
        logic [COL_W-1:0] center_col;
        logic [ROW_W-1:0] center_row;
        logic             frame_last;
    } t_result;

    logic [COL_W-1:0] r_col_max;
    logic [ROW_W-1:0] r_row_max;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    t_pix             r_win [3][3];

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic             accept, cfg_wr, cfg_hit, col_wrap, interior, produce, out_free;
    logic [WIDTH_W-1:0]  cfg_w;
    logic [HEIGHT_W-1:0] cfg_h;
    t_pix             up_pix, mid_pix;
    t_pix             p00, p01, p02, p10, p12, p20, p21, p22;
    logic [SUM_W-1:0] sx_pos, sx_neg, sy_pos, sy_neg;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [SUM_W-1:0] ax, ay;
    logic [MAG_W-1:0] mag;
    t_result          res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign cfg_hit     = cfg_wr & ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                   (i_cfg_index == REG_IMAGE_HEIGHT));
    assign cfg_w       = i_cfg_data[WIDTH_W-1:0];
    assign cfg_h       = i_cfg_data[HEIGHT_W-1:0];

    assign o_stall = r_skid_valid;
    assign accept  = i_valid & ~o_stall;

    assign col_wrap = (r_col == r_col_max);
    assign interior = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign produce  = accept & interior;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_wrap) begin
                n_col = '0;
                n_row = (r_row == r_row_max) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // read address runs one column ahead so data is ready at the accept edge
    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_upper (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (mid_pix),
        .i_rd_addr (n_col),
        .o_rd_data (up_pix)
    );

    sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_middle (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col),
        .i_wr_data (i_pixel),
        .i_rd_addr (n_col),
        .o_rd_data (mid_pix)
    );

    always_comb begin
        p00 = r_win[0][1];
        p01 = r_win[0][2];
        p02 = up_pix;
        p10 = r_win[1][1];
        p12 = mid_pix;
        p20 = r_win[2][1];
        p21 = r_win[2][2];
        p22 = i_pixel;
        sx_pos = SUM_W'(p02) + {1'b0, p12, 1'b0} + SUM_W'(p22);
        sx_neg = SUM_W'(p00) + {1'b0, p10, 1'b0} + SUM_W'(p20);
        sy_pos = SUM_W'(p20) + {1'b0, p21, 1'b0} + SUM_W'(p22);
        sy_neg = SUM_W'(p00) + {1'b0, p01, 1'b0} + SUM_W'(p02);
        gx  = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
        gy  = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
        ax  = gx[GRAD_W-1] ? SUM_W'(-gx) : SUM_W'(gx);
        ay  = gy[GRAD_W-1] ? SUM_W'(-gy) : SUM_W'(gy);
        mag = MAG_W'(ax) + MAG_W'(ay);
        res.edge_value = mag[PIX_W-1:0];
        res.center_col = r_col - COL_W'(1);
        res.center_row = r_row - ROW_W'(1);
        res.frame_last = col_wrap && (r_row == r_row_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_max <= RST_COL_MAX;
            r_row_max <= RST_ROW_MAX;
            r_col     <= '0;
            r_row     <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (cfg_wr && (i_cfg_index == REG_IMAGE_WIDTH)) begin
                if (cfg_w < WIDTH_W'(3)) begin
                    r_col_max <= COL_W'(2);
                end else if (cfg_w > WIDTH_W'(MAX_COLS)) begin
                    r_col_max <= COL_W'(MAX_COLS - 1);
                end else begin
                    r_col_max <= COL_W'(cfg_w - WIDTH_W'(1));
                end
            end
            if (cfg_wr && (i_cfg_index == REG_IMAGE_HEIGHT)) begin
                if (cfg_h < HEIGHT_W'(3)) begin
                    r_row_max <= ROW_W'(2);
                end else if (cfg_h > HEIGHT_W'(MAX_ROWS)) begin
                    r_row_max <= ROW_W'(MAX_ROWS - 1);
                end else begin
                    r_row_max <= ROW_W'(cfg_h - HEIGHT_W'(1));
                end
            end
            if (accept) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= up_pix;
                r_win[1][2] <= mid_pix;
                r_win[2][2] <= i_pixel;
            end
        end
    end

    // output register plus skid entry
    assign out_free = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (produce) begin
                r_out <= res;
            end
        end else if (produce) begin
            r_skid <= res;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_value = r_out.edge_value;
    assign o_center_col = r_out.center_col;
    assign o_center_row = r_out.center_row;
    assign o_frame_last = r_out.frame_last;

endmodule

// ===== hdl/sem_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== test/sobel_edge_magnitude_3x3_checker.sv =====
// Checker: watches the pixel, result and register channels, predicts each edge beat, compares.
`timescale 1ns / 100ps
module sobel_edge_magnitude_3x3_checker
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_pix_valid,
    input  logic                  i_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [PIX_W-1:0]      i_edge_value,
    input  logic [COL_W-1:0]      i_center_col,
    input  logic [ROW_W-1:0]      i_center_row,
    input  logic                  i_frame_last,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic [COL_W-1:0] center_col;
        logic [ROW_W-1:0] center_row;
        logic             frame_last;
    } edge_result_t;

    edge_result_t        edge_results_q[$];
    t_pix                upper_line  [MAX_COLS];
    t_pix                middle_line [MAX_COLS];
    t_pix                window_px   [3][3];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    int                  fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic score_pixel(input t_pix px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  idx;
        int           gx;
        int           gy;
        int           mag;
        edge_result_t res;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_COLS) ? MAX_COLS : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_ROWS) ? MAX_ROWS : height_reg;
        idx = col_pos % MAX_COLS;
        for (int k = 0; k < 3; k++) begin
            window_px[k][0] = window_px[k][1];
            window_px[k][1] = window_px[k][2];
        end
        window_px[0][2] = upper_line[idx];
        window_px[1][2] = middle_line[idx];
        window_px[2][2] = px;
        upper_line[idx] = middle_line[idx];
        middle_line[idx] = px;
        if (row_pos >= 2 && col_pos >= 2) begin
            gx = (int'(window_px[0][2]) + 2 * int'(window_px[1][2]) + int'(window_px[2][2]))
               - (int'(window_px[0][0]) + 2 * int'(window_px[1][0]) + int'(window_px[2][0]));
            gy = (int'(window_px[2][0]) + 2 * int'(window_px[2][1]) + int'(window_px[2][2]))
               - (int'(window_px[0][0]) + 2 * int'(window_px[0][1]) + int'(window_px[0][2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            res.edge_value = PIX_W'(mag);
            res.center_col = COL_W'(col_pos - 1);
            res.center_row = ROW_W'(row_pos - 1);
            res.frame_last = (col_pos == w - 1) && (row_pos == h - 1);
            edge_results_q.push_back(res);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    task automatic check_result();
        edge_result_t want;
        if (edge_results_q.size() == 0) begin
            report_mismatch($sformatf("edge beat with nothing expected: value %0d col %0d row %0d",
                                      i_edge_value, i_center_col, i_center_row));
        end else begin
            want = edge_results_q.pop_front();
            if (i_edge_value !== want.edge_value)
                report_mismatch($sformatf("edge_value at col %0d row %0d: got %0d, expected %0d",
                                          want.center_col, want.center_row,
                                          i_edge_value, want.edge_value));
            if (i_center_col !== want.center_col)
                report_mismatch($sformatf("center_col: got %0d, expected %0d",
                                          i_center_col, want.center_col));
            if (i_center_row !== want.center_row)
                report_mismatch($sformatf("center_row: got %0d, expected %0d",
                                          i_center_row, want.center_row));
            if (i_frame_last !== want.frame_last)
                report_mismatch($sformatf("frame_last at col %0d row %0d: got %0b, expected %0b",
                                          want.center_col, want.center_row,
                                          i_frame_last, want.frame_last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = WIDTH_W'(640);
            height_reg = HEIGHT_W'(480);
            col_pos = 0;
            row_pos = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    window_px[r][c] = '0;
                end
            end
            edge_results_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[WIDTH_W-1:0];
                        col_pos = 0;
                        row_pos = 0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data[HEIGHT_W-1:0];
                        col_pos = 0;
                        row_pos = 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_res_valid && !i_res_stall)
                check_result();
            if (i_pix_valid && !i_pix_stall)
                score_pixel(i_pixel);
        end
        o_pending <= edge_results_q.size();
    end

endmodule

// ===== test/tb_sobel_edge_magnitude_3x3_top.sv =====
// Testbench top: drives pixel frames and register writes into the Sobel block, gives the verdict.
`timescale 1ns / 100ps
module tb_sobel_edge_magnitude_3x3_top;
    import sem_pkg::*;

    localparam int RANDOM_PIXELS = 750;
    localparam int WIDE_COLS = 64;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_LIST = CFG_IDX_W'(15);

    // 3x3 frames, first pixel in the top byte
    localparam logic [71:0] FRAME_RISE    = 72'h0000FF_0000FF_FFFFFF;
    localparam logic [71:0] FRAME_FALL    = 72'hFFFF00_FFFF00_000000;
    localparam logic [71:0] FRAME_CHECKER = 72'h55AA55_AA55AA_55AA55;

    typedef enum int {PIX_RANDOM, PIX_BINARY, PIX_CONTRAST} t_pix_style;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic [PIX_W-1:0]      i_pixel = '0;
    logic                  i_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [PIX_W-1:0]      o_edge_value;
    logic [COL_W-1:0]      o_center_col;
    logic [ROW_W-1:0]      o_center_row;
    logic                  o_frame_last;
    logic                  o_cfg_ready;

    int fail_count;
    int pending_results;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit long_hold_req = 1'b0;
    int cur_w = 640;
    int cur_h = 480;

    sobel_edge_magnitude_3x3_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel      (i_pixel),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edge_value (o_edge_value),
        .o_center_col (o_center_col),
        .o_center_row (o_center_row),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    sobel_edge_magnitude_3x3_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_stall  (o_stall),
        .i_pixel      (i_pixel),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_edge_value (o_edge_value),
        .i_center_col (o_center_col),
        .i_center_row (o_center_row),
        .i_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int clamp_size(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic t_pix pick_pixel(input t_pix_style style);
        case (style)
            PIX_BINARY:   return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_CONTRAST: return $urandom_range(0, 1) ? PIX_W'($urandom_range(200, 255))
                                                      : PIX_W'($urandom_range(0, 40));
            default:      return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (index == REG_IMAGE_WIDTH)
            cur_w = clamp_size(int'(value[WIDTH_W-1:0]), 3, MAX_COLS);
        else if (index == REG_IMAGE_HEIGHT)
            cur_h = clamp_size(int'(value[HEIGHT_W-1:0]), 3, MAX_ROWS);
    endtask

    task automatic send_pixel(input t_pix px);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    // sender holds off until every predicted beat has come out, then lets the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_pattern(input logic [71:0] pat, input int first, input int last);
        for (int i = first; i <= last; i++)
            send_pixel(pat[71 - 8 * i -: 8]);
    endtask

    task automatic run_phase(input int count, input t_pix_style style);
        for (int i = 0; i < count; i++) begin
            send_pixel(pick_pixel(style));
            if ($urandom_range(0, 99) == 0)
                drain();
        end
        drain();
    endtask

    initial begin : receiver
        wait (i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int                    random_sent;
        int                    phase;
        int                    n;
        int                    pick;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CFG_DATA_W-1:0] hdata;
        t_pix_style            style;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frames: steep edges both ways, wrapping magnitudes, ignored index mid-frame
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        send_pattern(FRAME_RISE, 0, 8);
        send_pattern(FRAME_FALL, 0, 3);
        drain();
        write_reg(REG_OUT_OF_LIST, '1);
        send_pattern(FRAME_FALL, 4, 8);
        send_pattern(FRAME_CHECKER, 0, 8);
        drain();

        // wider rows, shortest frame through the low clamp, tall frame through the high clamp and at the limit
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(WIDE_COLS));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
        run_phase(3 * WIDE_COLS, PIX_RANDOM);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
        run_phase(45, PIX_CONTRAST);
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_ROWS));
        run_phase(45, PIX_BINARY);

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if (random_sent > RANDOM_PIXELS - 200) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                pick = $urandom_range(0, 3);
                tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : (pick == 2) ? 20 : 50;
                pick = $urandom_range(0, 3);
                rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 4 : (pick == 2) ? 20 : 50;
            end

            pick = $urandom_range(0, 99);
            if (pick < 8)
                wdata = CFG_DATA_W'($urandom_range(0, 2));
            else if (pick < 14)
                wdata = CFG_DATA_W'($urandom_range(3, 10))
                      | (CFG_DATA_W'($urandom_range(1, 3)) << 11);
            else
                wdata = CFG_DATA_W'($urandom_range(3, 10));
            hdata = ($urandom_range(0, 99) < 8) ? CFG_DATA_W'($urandom_range(0, 2))
                                                : CFG_DATA_W'($urandom_range(3, 7));
            if (phase == 0 || $urandom_range(0, 99) < 85)
                write_reg(REG_IMAGE_WIDTH, wdata);
            if (phase == 0 || $urandom_range(0, 99) < 85)
                write_reg(REG_IMAGE_HEIGHT, hdata);
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom()));

            if (phase == 2) begin
                n = 3 * cur_w * cur_h;
                long_hold_req = 1'b1;
            end else if ($urandom_range(0, 99) < 80) begin
                n = $urandom_range(1, 3) * cur_w * cur_h;
            end else begin
                n = $urandom_range(1, cur_w * cur_h);
            end
            style = t_pix_style'($urandom_range(0, 2));
            run_phase(n, style);
            random_sent += n;
            phase++;
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
